@@ rtl/core/farthest_point_sampler_assert.svh @@
// Assertion macros for the farthest point sampler.
// Expects signals named clk and rst in the scope of each use.
`ifndef FARTHEST_POINT_SAMPLER_ASSERT_SVH
`define FARTHEST_POINT_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define FPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FPS_ASSERT_IMP(lbl, ante, cons, msg)
`define FPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/fps_pkg.sv @@
// Shared constants, status codes and the command control type of the sampler.
// No dependencies.
package fps_pkg;

  localparam int MAX_POINTS_DEF  = 1024;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;

  localparam int SAMPLE_W = 7;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SAMPLES = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED    = 2'd3;

  typedef struct packed {
    logic keep;  // point has a slot in the store
    logic last;  // final point: start a run
    logic ovf;   // some point of this cloud was dropped
  } fps_ctl_t;

endpackage

@@ rtl/core/fps_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/fps_front.sv @@
// Front end: accepts points, assigns store slots, flags drops and queues commands.
// Depends on fps_pkg.
module fps_front import fps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  logic [COORD_BITS-1:0] z,
  input  logic                  last,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output logic [COORD_BITS-1:0] cmd_x,
  output logic [COORD_BITS-1:0] cmd_y,
  output logic [COORD_BITS-1:0] cmd_z,
  output logic [IW-1:0]         cmd_index,
  output logic [CW-1:0]         cmd_total,
  output fps_ctl_t              cmd_ctl
);

  localparam int C   = COORD_BITS;
  localparam int E_W = 3 * C + IW + CW + $bits(fps_ctl_t);

  logic [CW-1:0]  total;
  logic           ovf;
  logic           keep;
  logic [CW-1:0]  total_next;
  fps_ctl_t       ctl_in;
  logic [E_W-1:0] entry;
  logic [E_W-1:0] q_data [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  assign keep       = (total < CW'(MAX_POINTS));
  assign total_next = keep ? total + CW'(1) : total;

  always_comb begin
    ctl_in.keep = keep;
    ctl_in.last = last;
    ctl_in.ovf  = ovf || !keep;
    entry       = {x, y, z, total[IW-1:0], total_next, ctl_in};
  end

  assign {cmd_x, cmd_y, cmd_z, cmd_index, cmd_total, cmd_ctl} = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      ovf    <= 1'b0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
        // a finished cloud restarts the count for the next one
        if (last) begin
          total <= '0;
          ovf   <= 1'b0;
        end else begin
          total <= total_next;
          ovf   <= ctl_in.ovf;
        end
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/fps_back.sv @@
// Back end: stores points, runs the selection rounds and emits the kept points or a status report.
// Depends on fps_pkg and fps_ram.
module fps_back import fps_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SAMPLE_W-1:0]   sample_count,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic [COORD_BITS-1:0] cmd_x,
  input  logic [COORD_BITS-1:0] cmd_y,
  input  logic [COORD_BITS-1:0] cmd_z,
  input  logic [IW-1:0]         cmd_index,
  input  logic [CW-1:0]         cmd_total,
  input  fps_ctl_t              cmd_ctl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    point_index,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [COORD_BITS-1:0] out_z,
  output logic [STATUS_W-1:0]   status,
  output logic                  run_end
);

  localparam int C     = COORD_BITS;
  localparam int DW    = 2 * C + 2;
  localparam int CMP_W = (CW > SAMPLE_W) ? CW : SAMPLE_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_START   = 9'b000000010,
    S_REPORT  = 9'b000000100,
    S_SEL     = 9'b000001000,
    S_SELW    = 9'b000010000,
    S_SWEEP   = 9'b000100000,
    S_DRAIN   = 9'b001000000,
    S_OUT_RD  = 9'b010000000,
    S_OUT_CHK = 9'b100000000
  } state_t;

  state_t              state;
  logic [CW-1:0]       run_total;
  logic                run_ovf;
  logic [SAMPLE_W-1:0] ns;
  logic [SAMPLE_W-1:0] ns_sat;
  logic                all_mode;
  logic                first_round;
  logic [SAMPLE_W-1:0] round;
  logic [IW-1:0]       choice;
  logic [IW-1:0]       sel_idx;
  logic [C-1:0]        sel_x, sel_y, sel_z;
  logic [DW-1:0]       best;
  logic [IW-1:0]       j;
  logic [CW-1:0]       marks;
  logic [CW-1:0]       emitted;
  logic [STATUS_W-1:0] report_code;

  // sweep pipeline
  logic                p1_valid, p2_valid;
  logic [IW-1:0]       p1_j, p2_j;
  logic [2*C-1:0]      sq_x, sq_y, sq_z;
  logic [DW-1:0]       old_min;
  logic                old_mark;

  logic                pt_wr_en;
  logic [IW-1:0]       pt_rd_addr;
  logic [3*C-1:0]      pt_rd;
  logic [DW:0]         dist_rd;
  logic [DW:0]         dist_wr;

  logic signed [C:0]     dx, dy, dz;
  logic signed [2*C+1:0] px, py, pz;
  logic [DW-1:0]         d_sum;
  logic [DW-1:0]         min_new;
  logic                  mark_new;
  logic                  out_free;
  logic                  out_ld;
  logic                  hit;
  logic [CMP_W-1:0]      ns_w, tot_w;

  assign cmd_ready = (state == S_IDLE);
  assign pt_wr_en  = (state == S_IDLE) && cmd_valid && cmd_ctl.keep;
  assign pt_rd_addr = (state == S_SEL) ? choice : j;
  assign ns_sat = (sample_count > SAMPLE_W'(MAX_SAMPLES)) ? SAMPLE_W'(MAX_SAMPLES)
                                                          : sample_count;
  assign ns_w  = CMP_W'(ns);
  assign tot_w = CMP_W'(run_total);

  fps_ram #(.WIDTH(3 * C), .DEPTH(MAX_POINTS)) u_points (
    .clk     (clk),
    .wr_en   (pt_wr_en),
    .wr_addr (cmd_index),
    .wr_data ({cmd_x, cmd_y, cmd_z}),
    .rd_addr (pt_rd_addr),
    .rd_data (pt_rd)
  );

  fps_ram #(.WIDTH(DW + 1), .DEPTH(MAX_POINTS)) u_dist (
    .clk     (clk),
    .wr_en   (p2_valid),
    .wr_addr (p2_j),
    .wr_data (dist_wr),
    .rd_addr (j),
    .rd_data (dist_rd)
  );

  // stage 1: per-axis differences and squares
  always_comb begin
    dx = {pt_rd[3*C-1], pt_rd[3*C-1:2*C]} - {sel_x[C-1], sel_x};
    dy = {pt_rd[2*C-1], pt_rd[2*C-1:C]}   - {sel_y[C-1], sel_y};
    dz = {pt_rd[C-1],   pt_rd[C-1:0]}     - {sel_z[C-1], sel_z};
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  // stage 2: sum, lower the running minimum, set the mark
  always_comb begin
    d_sum    = DW'(sq_x) + DW'(sq_y) + DW'(sq_z);
    min_new  = (d_sum < old_min) ? d_sum : old_min;
    mark_new = old_mark || (p2_j == sel_idx);
    dist_wr  = {mark_new, min_new};
  end

  always_ff @(posedge clk) begin
    p1_j <= j;
    p2_j <= p1_j;
    sq_x <= px[2*C-1:0];
    sq_y <= py[2*C-1:0];
    sq_z <= pz[2*C-1:0];
    // the first round starts from an unmarked entry at full distance
    if (first_round) begin
      old_min  <= {DW{1'b1}};
      old_mark <= 1'b0;
    end else begin
      old_min  <= dist_rd[DW-1:0];
      old_mark <= dist_rd[DW];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign hit      = all_mode || dist_rd[DW];
  assign out_ld   = out_free && ((state == S_REPORT) || ((state == S_OUT_CHK) && hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      p1_valid    <= 1'b0;
      p2_valid    <= 1'b0;
      run_total   <= '0;
      run_ovf     <= 1'b0;
      ns          <= '0;
      all_mode    <= 1'b0;
      first_round <= 1'b0;
      round       <= '0;
      choice      <= '0;
      sel_idx     <= '0;
      best        <= '0;
      j           <= '0;
      marks       <= '0;
      emitted     <= '0;
      report_code <= STATUS_OK;
    end else begin
      p1_valid <= (state == S_SWEEP);
      p2_valid <= p1_valid;
      if (p2_valid) begin
        if (min_new > best) begin
          best   <= min_new;
          choice <= p2_j;
        end
        if ((p2_j == sel_idx) && !old_mark) begin
          marks <= marks + CW'(1);
        end
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ctl.last) begin
            run_total <= cmd_total;
            run_ovf   <= cmd_ctl.ovf;
            ns        <= ns_sat;
            state     <= S_START;
          end
        end
        S_START: begin
          choice   <= '0;
          round    <= '0;
          marks    <= '0;
          emitted  <= '0;
          all_mode <= 1'b0;
          j        <= '0;
          if (ns == '0) begin
            report_code <= STATUS_NO_SAMPLES;
            state       <= S_REPORT;
          end else if (ns_w > tot_w) begin
            report_code <= STATUS_TOO_FEW;
            state       <= S_REPORT;
          end else if (ns_w == tot_w) begin
            all_mode <= 1'b1;
            marks    <= run_total;
            state    <= S_OUT_RD;
          end else begin
            first_round <= 1'b1;
            state       <= S_SEL;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SEL: begin
          state <= S_SELW;
        end
        S_SELW: begin
          sel_x   <= pt_rd[3*C-1:2*C];
          sel_y   <= pt_rd[2*C-1:C];
          sel_z   <= pt_rd[C-1:0];
          sel_idx <= choice;
          best    <= '0;
          j       <= '0;
          state   <= S_SWEEP;
        end
        S_SWEEP: begin
          if ((CW'(j) + CW'(1)) == run_total) begin
            state <= S_DRAIN;
          end else begin
            j <= j + IW'(1);
          end
        end
        S_DRAIN: begin
          if (!p1_valid && !p2_valid) begin
            first_round <= 1'b0;
            if ((round + SAMPLE_W'(1)) == ns) begin
              j     <= '0;
              state <= S_OUT_RD;
            end else begin
              round <= round + SAMPLE_W'(1);
              state <= S_SEL;
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_CHK;
        end
        S_OUT_CHK: begin
          if (!hit) begin
            j     <= j + IW'(1);
            state <= S_OUT_RD;
          end else if (out_free) begin
            emitted <= emitted + CW'(1);
            if ((emitted + CW'(1)) == marks) begin
              state <= S_IDLE;
            end else begin
              j     <= j + IW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      if (state == S_REPORT) begin
        point_index <= '0;
        out_x       <= '0;
        out_y       <= '0;
        out_z       <= '0;
        status      <= report_code;
        run_end     <= 1'b1;
      end else begin
        point_index <= INDEX_W'(j);
        out_x       <= pt_rd[3*C-1:2*C];
        out_y       <= pt_rd[2*C-1:C];
        out_z       <= pt_rd[C-1:0];
        status      <= run_ovf ? STATUS_DROPPED : STATUS_OK;
        run_end     <= ((emitted + CW'(1)) == marks);
      end
    end
  end

endmodule

@@ rtl/core/farthest_point_sampler.sv @@
// Farthest point sampler top level: front end, command queue and back end.
// Loading: one point per cycle while in_ready is high. The final point of a cloud
// starts the selection rounds and then the readout, both paced by the single
// read port of the point and distance memories.
// Reset (rst, synchronous) empties the queue and clears counts; memories keep contents.
`include "farthest_point_sampler_assert.svh"
module farthest_point_sampler import fps_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  logic [COORD_BITS-1:0] z,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    point_index,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [COORD_BITS-1:0] out_z,
  output logic [STATUS_W-1:0]   status,
  output logic                  run_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SAMPLE_W-1:0]   cfg_data
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [SAMPLE_W-1:0]   sample_count;
  logic                  cmd_valid;
  logic                  cmd_ready;
  logic [COORD_BITS-1:0] cmd_x, cmd_y, cmd_z;
  logic [IW-1:0]         cmd_index;
  logic [CW-1:0]         cmd_total;
  fps_ctl_t              cmd_ctl;

  // Configuration: always ready; hold the round count for the next run.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      sample_count <= cfg_data;
    end
  end

  // Front end: number each point, drop those beyond the store, queue the transfer.
  fps_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x         (x),
    .y         (y),
    .z         (z),
    .last      (last),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .cmd_z     (cmd_z),
    .cmd_index (cmd_index),
    .cmd_total (cmd_total),
    .cmd_ctl   (cmd_ctl)
  );

  // Back end: write the store, run the rounds, stream out marked points in
  // index order through its output register.
  fps_back #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .sample_count (sample_count),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd_x        (cmd_x),
    .cmd_y        (cmd_y),
    .cmd_z        (cmd_z),
    .cmd_index    (cmd_index),
    .cmd_total    (cmd_total),
    .cmd_ctl      (cmd_ctl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_index  (point_index),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .status       (status),
    .run_end      (run_end)
  );

  // A run start stops the back end taking further commands.
  `FPS_ASSERT_NXT(a_run_holds_queue, cmd_valid && cmd_ready && cmd_ctl.last, !cmd_ready, "back end took a command during a run")
  // A dropped point always carries the overflow flag.
  `FPS_ASSERT_IMP(a_drop_flagged, cmd_valid && !cmd_ctl.keep, cmd_ctl.ovf, "dropped point without overflow flag")
  // Error reports are single-result runs.
  `FPS_ASSERT_IMP(a_error_ends_run, out_valid && (status == STATUS_NO_SAMPLES || status == STATUS_TOO_FEW), run_end, "error result without run end")

endmodule

@@ verif/fps_checker.sv @@
// Checker for the farthest point sampler: watches the point, result and
// sample-count channels, predicts each run and compares. Depends on fps_pkg.
`timescale 1ns / 100ps
module fps_checker import fps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [15:0]         x,
  input  logic [15:0]         y,
  input  logic [15:0]         z,
  input  logic                last,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [INDEX_W-1:0]  point_index,
  input  logic [15:0]         out_x,
  input  logic [15:0]         out_y,
  input  logic [15:0]         out_z,
  input  logic [STATUS_W-1:0] status,
  input  logic                run_end,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [SAMPLE_W-1:0] cfg_data,
  output int                  errors,
  output int                  pending
);

  localparam int STORE_DEPTH = MAX_POINTS_DEF;
  localparam int SAMPLE_CAP  = MAX_SAMPLES_DEF;

  typedef struct packed {
    logic [INDEX_W-1:0]  idx;
    logic [15:0]         px;
    logic [15:0]         py;
    logic [15:0]         pz;
    logic [STATUS_W-1:0] st;
    logic                fin;
  } kept_point_t;

  kept_point_t kept_q[$];

  logic signed [15:0] cloud_x [STORE_DEPTH];
  logic signed [15:0] cloud_y [STORE_DEPTH];
  logic signed [15:0] cloud_z [STORE_DEPTH];
  logic [33:0]        nearest [STORE_DEPTH];
  logic               picked  [STORE_DEPTH];
  int                 cloud_size;
  logic               dropped;
  logic [SAMPLE_W-1:0] rounds_reg;

  function automatic logic [33:0] dist2(int a, int b);
    longint dx, dy, dz;
    dx = longint'(cloud_x[a]) - longint'(cloud_x[b]);
    dy = longint'(cloud_y[a]) - longint'(cloud_y[b]);
    dz = longint'(cloud_z[a]) - longint'(cloud_z[b]);
    return 34'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Run greedy selection over the loaded cloud and queue the kept points or an error result.
  task automatic select_points();
    int ns, cur, sel, emitted, last_slot;
    logic [33:0] best, d;
    logic [STATUS_W-1:0] st;
    kept_point_t k;
    ns = (rounds_reg > SAMPLE_CAP) ? SAMPLE_CAP : int'(rounds_reg);
    st = dropped ? STATUS_DROPPED : STATUS_OK;
    if (ns == 0) begin
      k = '{0, 0, 0, 0, STATUS_NO_SAMPLES, 1'b1};
      kept_q.insert(kept_q.size(), k);
    end else if (ns > cloud_size) begin
      k = '{0, 0, 0, 0, STATUS_TOO_FEW, 1'b1};
      kept_q.insert(kept_q.size(), k);
    end else begin
      for (int j = 0; j < cloud_size; j++) begin
        nearest[j] = '1;
        picked[j] = 1'b0;
      end
      cur = 0;
      if (ns == cloud_size) begin
        for (int j = 0; j < cloud_size; j++) picked[j] = 1'b1;
      end else begin
        for (int i = 0; i < ns; i++) begin
          sel = cur;
          best = '0;
          picked[sel] = 1'b1;
          for (int j = 0; j < cloud_size; j++) begin
            d = dist2(j, sel);
            if (d < nearest[j]) nearest[j] = d;
            if (nearest[j] > best) begin
              best = nearest[j];
              cur = j;
            end
          end
        end
      end
      emitted = 0;
      last_slot = 0;
      for (int j = 0; j < cloud_size && emitted < SAMPLE_CAP; j++) begin
        if (picked[j]) begin
          k = '{INDEX_W'(j), cloud_x[j], cloud_y[j], cloud_z[j], st, 1'b0};
          kept_q.insert(kept_q.size(), k);
          emitted++;
        end
      end
      if (emitted > 0) kept_q[kept_q.size() - 1].fin = 1'b1;
    end
    cloud_size = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    kept_point_t want;
    if (rst) begin
      cloud_size = 0;
      dropped = 1'b0;
      rounds_reg = '0;
      kept_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) rounds_reg = cfg_data;
      if (in_valid && in_ready) begin
        if (cloud_size < STORE_DEPTH) begin
          cloud_x[cloud_size] = x;
          cloud_y[cloud_size] = y;
          cloud_z[cloud_size] = z;
          cloud_size++;
        end else begin
          dropped = 1'b1;
        end
        if (last) select_points();
      end
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: idx %0d status %0d", point_index, status);
        end else begin
          want = kept_q.pop_front();
          if (want !== {point_index, out_x, out_y, out_z, status, run_end}) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected idx %0d xyz %0d %0d %0d st %0d end %0d, got idx %0d xyz %0d %0d %0d st %0d end %0d",
                       want.idx, $signed(want.px), $signed(want.py), $signed(want.pz),
                       want.st, want.fin, point_index, $signed(out_x), $signed(out_y),
                       $signed(out_z), status, run_end);
          end
        end
      end
    end
    pending = kept_q.size();
  end

endmodule

@@ verif/farthest_point_sampler_test.sv @@
// Testbench top for the farthest point sampler: clock, reset, stimulus and
// verdict. Depends on fps_pkg, fps_checker and the sampler RTL.
`timescale 1ns / 100ps
module farthest_point_sampler_test;
  import fps_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [15:0]         x = '0, y = '0, z = '0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [INDEX_W-1:0]  point_index;
  logic [15:0]         out_x, out_y, out_z;
  logic [STATUS_W-1:0] status;
  logic                run_end;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SAMPLE_W-1:0] cfg_data = '0;
  int                  errors;
  int                  pending;
  int                  points_sent = 0;
  logic                quiet = 1'b0;  // no idling in the closing stretch

  farthest_point_sampler dut (.*);

  fps_checker checker_i (.*);

  always #4 clk = ~clk;

  // Receiver: stall in random bursts, or keep ready high once quiet.
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      stall = $urandom_range(1, 19);
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  // Hold the sample-count write until it is taken, then drop it.
  task automatic write_rounds(input logic [SAMPLE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Present one point; an optional gap comes first, and valid stays high
  // across back-to-back transfers.
  task automatic send_point(input logic [15:0] px, py, pz, input logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    x <= px;
    y <= py;
    z <= pz;
    last <= fin;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  function automatic logic [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 6) - 3);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'h1234;
    endcase
  endfunction

  // Send a whole cloud; mode 3 repeats one point throughout.
  task automatic send_cloud(input int n, input int mode);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1);
    in_valid <= 1'b0;
  endtask

  // Let the checker see the last transfer, wait for every kept point, then
  // let the block settle.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  initial begin
    int n, r, cnt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: no samples, equal count, too few, duplicates, extremes.
    write_rounds(0);   send_cloud(1, 2); drain();
    write_rounds(1);   send_cloud(1, 2); drain();
    write_rounds(2);   send_cloud(1, 0); drain();
    write_rounds(3);   send_cloud(4, 3); drain();
    write_rounds(5);   send_cloud(8, 2); drain();
    write_rounds(127); send_cloud(3, 1); drain();

    // Larger cloud with a saturated count.
    write_rounds(127); send_cloud(70, 0); drain();

    // Random clouds, mostly small, with the odd degenerate count.
    while (points_sent < 205) begin
      if (points_sent >= 170) quiet = 1'b1;
      n = $urandom_range(2, 12);
      r = $urandom_range(0, 9);
      if (r == 0)      cnt = 0;
      else if (r == 1) cnt = n + $urandom_range(1, 3);
      else if (r == 2) cnt = $urandom_range(65, 127);
      else             cnt = $urandom_range(1, n);
      write_rounds(SAMPLE_W'(cnt));
      send_cloud(n, $urandom_range(0, 3) == 0 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0));
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
